### rtl/kcl_pkg.sv
// Package for the keypad code lock with arming stages.
// Holds key codes, event codes, register indexes and buffer sizing.
// No dependencies.
`timescale 1ns / 1ps

package kcl_pkg;

  // entry buffer sizing
  localparam int MAX_DIGITS = 10;
  localparam int CODE_SLOTS = 10;
  localparam int LEN_LIMIT  = (MAX_DIGITS < CODE_SLOTS) ? MAX_DIGITS : CODE_SLOTS;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam int KEY_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int CODE_W     = CODE_SLOTS * DIGIT_W;
  localparam int LEN_W      = 4;

  localparam logic [CODE_W-1:0] CODE_DIGITS_RST = CODE_W'(17185);
  localparam logic [LEN_W-1:0]  CODE_LENGTH_RST = LEN_W'(4);

  // keypad codes
  localparam logic [KEY_W-1:0] KEY_NONE     = 4'd0;
  localparam logic [KEY_W-1:0] KEY_DIGIT_LO = 4'd1;
  localparam logic [KEY_W-1:0] KEY_DIGIT_HI = 4'd10;
  localparam logic [KEY_W-1:0] KEY_STAR     = 4'd11;
  localparam logic [KEY_W-1:0] KEY_HASH     = 4'd12;

  // configuration register indexes
  localparam logic CFG_CODE_DIGITS = 1'b0;
  localparam logic CFG_CODE_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DIGIT    = 3'd1,
    EV_CLEARED  = 3'd2,
    EV_MATCH    = 3'd3,
    EV_MISMATCH = 3'd4,
    EV_OVERFLOW = 3'd5
  } kev_t;

  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_buf_t;

endpackage

### rtl/kcl_if.sv
// Channel interfaces for the keypad code lock: input, result and config.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

interface kcl_in_if
  import kcl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             safety_switch;
  logic             fire_switch;

  modport source (output valid, key, safety_switch, fire_switch, input ready);
  modport sink   (input valid, key, safety_switch, fire_switch, output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic       unlocked;
  logic       safety_ready;
  logic       fire_ready;
  logic [2:0] key_event;
  logic       reset_signal;

  modport source (output valid, unlocked, safety_ready, fire_ready, key_event,
                  reset_signal, input ready);
  modport sink   (input valid, unlocked, safety_ready, fire_ready, key_event,
                  reset_signal, output ready);
endinterface

interface kcl_cfg_if
  import kcl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              index;
  logic [CODE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/kcl_match.sv
// Passcode comparator: entry buffer and count against stored code and length.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_match
  import kcl_pkg::*;
(
  input  digit_buf_t        digits,
  input  logic [CNT_W-1:0]  count,
  input  logic [CODE_W-1:0] code_digits,
  input  logic [LEN_W-1:0]  code_length,
  output logic              match
);

  logic [MAX_DIGITS-1:0] digit_ok;
  logic                  len_ok;

  // length beyond buffer or code slots never matches
  assign len_ok = (5'(code_length) <= 5'(LEN_LIMIT))
                  && (count == CNT_W'(code_length));

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_digit
    localparam logic [CNT_W-1:0] POS = CNT_W'(i);
    if (i < CODE_SLOTS) begin : g_cmp
      assign digit_ok[i] = (count <= POS)
                           || (digits[i] == code_digits[i*DIGIT_W +: DIGIT_W]);
    end else begin : g_out
      // only reachable with length above the code slots, rejected by len_ok
      assign digit_ok[i] = (count <= POS);
    end
  end

  assign match = len_ok && (&digit_ok);

endmodule

### rtl/keypad_code_lock_with_arming_core.sv
// Keypad code lock with safety and fire arming stages, top level.
// Depends on kcl_pkg, kcl_if (channel interfaces) and kcl_match.
`timescale 1ns / 1ps

// One input transfer carries a decoded key and both switch levels; each one
// yields exactly one result transfer showing the three stage flags after the
// item, the key event and whether a reset sequence was triggered. The block
// takes one item per clock: switches, key decode and the parallel passcode
// compare all sit between the state registers and the result register, and
// in_ch.ready stays high while the result register is empty or being drained,
// so throughput is one item per cycle with each result registered. The config
// port (code digits at index 0, code length at index 1) is always ready and
// should only be written while no item is in flight.

module keypad_code_lock_with_arming_core
  import kcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  kcl_in_if.sink    in_ch,
  kcl_out_if.source out_ch,
  kcl_cfg_if.sink   cfg_ch
);

  // configuration
  logic [CODE_W-1:0] code_digits_r;
  logic [LEN_W-1:0]  code_length_r;

  // lock state
  digit_buf_t        digits_r;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic              lock_r,   lock_nxt;
  logic              safety_r, safety_nxt;
  logic              fire_r,   fire_nxt;
  logic              dig_wr;

  // result register
  logic              out_valid_r;
  logic              unlocked_r, safety_ready_r, fire_ready_r, reset_sig_r;
  kev_t              key_event_r;
  kev_t              ev_nxt;
  logic              rst_sig_nxt;

  logic              accept;
  logic              match;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  kcl_match u_match (
    .digits      (digits_r),
    .count       (count_r),
    .code_digits (code_digits_r),
    .code_length (code_length_r),
    .match       (match)
  );

  // switches first, then the key
  always_comb begin
    lock_nxt    = lock_r;
    safety_nxt  = safety_r;
    fire_nxt    = fire_r;
    count_nxt   = count_r;
    dig_wr      = 1'b0;
    ev_nxt      = EV_NONE;
    rst_sig_nxt = 1'b0;

    if (in_ch.safety_switch) begin
      if (lock_r) begin
        safety_nxt = 1'b1;
      end else begin
        safety_nxt  = 1'b0;
        rst_sig_nxt = 1'b1;
      end
    end

    // out-of-sequence fire drops every stage
    if (in_ch.fire_switch) begin
      if (lock_r && safety_nxt) begin
        fire_nxt = 1'b1;
      end else begin
        fire_nxt    = 1'b0;
        safety_nxt  = 1'b0;
        lock_nxt    = 1'b0;
        rst_sig_nxt = 1'b1;
      end
    end

    unique case (in_ch.key) inside
      KEY_STAR: begin
        count_nxt   = '0;
        lock_nxt    = 1'b0;
        rst_sig_nxt = 1'b1;
        ev_nxt      = EV_CLEARED;
      end
      KEY_HASH: begin
        count_nxt = '0;
        if (match) begin
          lock_nxt = 1'b1;
          ev_nxt   = EV_MATCH;
        end else begin
          lock_nxt    = 1'b0;
          rst_sig_nxt = 1'b1;
          ev_nxt      = EV_MISMATCH;
        end
      end
      [KEY_DIGIT_LO:KEY_DIGIT_HI]: begin
        if (count_r < CNT_W'(MAX_DIGITS)) begin
          dig_wr    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ev_nxt    = EV_DIGIT;
        end else begin
          // buffer full: drop the entry and lock
          count_nxt   = '0;
          lock_nxt    = 1'b0;
          rst_sig_nxt = 1'b1;
          ev_nxt      = EV_OVERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_digits_r <= CODE_DIGITS_RST;
      code_length_r <= CODE_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CODE_DIGITS: code_digits_r <= cfg_ch.data;
        CFG_CODE_LENGTH: code_length_r <= cfg_ch.data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      lock_r   <= 1'b0;
      safety_r <= 1'b0;
      fire_r   <= 1'b0;
    end else if (accept) begin
      count_r  <= count_nxt;
      lock_r   <= lock_nxt;
      safety_r <= safety_nxt;
      fire_r   <= fire_nxt;
    end
  end

  // entries at or above the count are never read, so no clear is needed
  always_ff @(posedge clk) begin
    if (accept && dig_wr) begin
      digits_r[count_r[IDX_W-1:0]] <= DIGIT_W'(in_ch.key - KEY_DIGIT_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unlocked_r     <= lock_nxt;
      safety_ready_r <= lock_nxt && safety_nxt;
      fire_ready_r   <= lock_nxt && safety_nxt && fire_nxt;
      key_event_r    <= ev_nxt;
      reset_sig_r    <= rst_sig_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.unlocked     = unlocked_r;
  assign out_ch.safety_ready = safety_ready_r;
  assign out_ch.fire_ready   = fire_ready_r;
  assign out_ch.key_event    = key_event_r;
  assign out_ch.reset_signal = reset_sig_r;

endmodule

### verif/kcl_lock_checker.sv
// Scoreboard for the keypad code lock: watches the input, result and config
// channels, predicts each result and compares it field by field.
// Depends on kcl_pkg and the channel interfaces in kcl_if.
`timescale 1ns / 1ps

module kcl_lock_checker
  import kcl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  kcl_in_if    in_mon,
  kcl_out_if   out_mon,
  kcl_cfg_if   cfg_mon,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic unlocked;
    logic safety_ready;
    logic fire_ready;
    kev_t kev;
    logic reset_signal;
  } lock_flags_t;

  // shadow of the block state and registers
  logic [CODE_W-1:0]  code_word;
  logic [LEN_W-1:0]   code_len;
  logic [DIGIT_W-1:0] entry_digit [MAX_DIGITS];
  int                 entry_count;
  logic               lock_open;
  logic               safety_set;
  logic               fire_set;

  lock_flags_t expected_flags [$];
  lock_flags_t want;

  // switches first, then the key
  task automatic predict_keypress(input logic [KEY_W-1:0] key, input logic sw_safety,
                                  input logic sw_fire, output lock_flags_t res);
    kev_t kev;
    logic rs;
    logic hit;
    kev = EV_NONE;
    rs  = 1'b0;
    if (sw_safety) begin
      if (lock_open) begin
        safety_set = 1'b1;
      end else begin
        safety_set = 1'b0;
        rs = 1'b1;
      end
    end
    if (sw_fire) begin
      if (lock_open && safety_set) begin
        fire_set = 1'b1;
      end else begin
        fire_set   = 1'b0;
        safety_set = 1'b0;
        lock_open  = 1'b0;
        rs = 1'b1;
      end
    end
    if (key == KEY_STAR) begin
      entry_count = 0;
      lock_open   = 1'b0;
      rs  = 1'b1;
      kev = EV_CLEARED;
    end else if (key == KEY_HASH) begin
      hit = (int'(code_len) <= LEN_LIMIT) && (entry_count == int'(code_len));
      for (int i = 0; i < entry_count; i++) begin
        if (entry_digit[i] != code_word[DIGIT_W*i +: DIGIT_W]) hit = 1'b0;
      end
      if (hit) begin
        lock_open = 1'b1;
        kev = EV_MATCH;
      end else begin
        lock_open = 1'b0;
        rs  = 1'b1;
        kev = EV_MISMATCH;
      end
      entry_count = 0;
    end else if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
      if (entry_count < MAX_DIGITS) begin
        entry_digit[entry_count] = key - KEY_DIGIT_LO;
        entry_count++;
        kev = EV_DIGIT;
      end else begin
        entry_count = 0;
        lock_open   = 1'b0;
        rs  = 1'b1;
        kev = EV_OVERFLOW;
      end
    end
    res.unlocked     = lock_open;
    res.safety_ready = lock_open && safety_set;
    res.fire_ready   = lock_open && safety_set && fire_set;
    res.kev          = kev;
    res.reset_signal = rs;
  endtask

  task automatic compare_field(input string label, input logic [2:0] expv,
                               input logic [2:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      code_word   = CODE_DIGITS_RST;
      code_len    = CODE_LENGTH_RST;
      entry_count = 0;
      lock_open   = 1'b0;
      safety_set  = 1'b0;
      fire_set    = 1'b0;
      fail_count  = 0;
      expected_flags.delete();
      outstanding <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_CODE_DIGITS) code_word = cfg_mon.data;
        else code_len = cfg_mon.data[LEN_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_keypress(in_mon.key, in_mon.safety_switch, in_mon.fire_switch, want);
        expected_flags.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_flags.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual event %0d",
                   $time, out_mon.key_event);
          fail_count++;
        end else begin
          want = expected_flags.pop_front();
          compare_field("unlocked", 3'(want.unlocked), 3'(out_mon.unlocked));
          compare_field("safety_ready", 3'(want.safety_ready), 3'(out_mon.safety_ready));
          compare_field("fire_ready", 3'(want.fire_ready), 3'(out_mon.fire_ready));
          compare_field("key_event", want.kev, out_mon.key_event);
          compare_field("reset_signal", 3'(want.reset_signal), 3'(out_mon.reset_signal));
        end
      end
      outstanding <= expected_flags.size();
    end
  end

endmodule

### verif/keypad_code_lock_with_arming_core_test.sv
// Top of the keypad code lock testbench: clock, reset, stimulus and verdict.
// Depends on kcl_pkg, kcl_if, keypad_code_lock_with_arming_core and
// kcl_lock_checker.
`timescale 1ns / 1ps

module keypad_code_lock_with_arming_core_test
  import kcl_pkg::*;
;

  // generous bound for a clean run
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;

  int fail_count;
  int outstanding;
  int cycle_count;
  int sent_count;
  int burst_left;

  // our copy of what the lock has been told, used to build real entries
  logic [CODE_W-1:0] cur_code;
  logic [LEN_W-1:0]  cur_len;

  rx_mode_t   rx_mode;
  logic [7:0] rx_tick;

  kcl_in_if  in_ch ();
  kcl_out_if out_ch ();
  kcl_cfg_if cfg_ch ();

  keypad_code_lock_with_arming_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  kcl_lock_checker lock_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side backpressure. The mode is redrawn whenever rx_tick[6:0] is zero, so
  // stalls land on every phase of the traffic, with fully open stretches in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_tick      <= '0;
      rx_mode      <= RX_ALWAYS;
      out_ch.ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (rx_tick[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  out_ch.ready <= 1'($urandom_range(0, 1));
        default:   out_ch.ready <= (rx_tick[3:0] < 4'd11);
      endcase
    end
  end

  // A stray switch level now and then while a code is keyed in
  function automatic logic stray_level();
    return ($urandom_range(0, 19) == 0);
  endfunction

  // Random passcode with every nibble a decimal digit
  function automatic logic [CODE_W-1:0] decimal_code();
    logic [CODE_W-1:0] c;
    for (int i = 0; i < CODE_SLOTS; i++) c[DIGIT_W*i +: DIGIT_W] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // One input transfer. The sender runs in bursts: when a burst is used up,
  // valid drops for a random gap (possibly none) and a new burst length is
  // drawn, sometimes a long one so there are stretches with no idling.
  task automatic send_keypress(input logic [KEY_W-1:0] k, input logic saf,
                               input logic fir);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.key           <= k;
    in_ch.safety_switch <= saf;
    in_ch.fire_switch   <= fir;
    do @(posedge clk); while (!in_ch.ready);
    // unused key codes with idle switches do nothing, so they are not counted
    if (k <= KEY_HASH || saf || fir) sent_count++;
  endtask

  // Leaves cfg valid high; the caller drops it once its writes are done
  task automatic write_register(input logic idx, input logic [CODE_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_CODE_DIGITS) cur_code = val;
    else cur_len = val[LEN_W-1:0];
  endtask

  // Length word carries junk above the low nibble; only the nibble counts.
  task automatic load_passcode(input logic [CODE_W-1:0] digits, input logic [3:0] len);
    logic [CODE_W-1:0] len_word;
    len_word = {8'($urandom), 32'($urandom)};
    len_word[LEN_W-1:0] = len;
    write_register(CFG_CODE_DIGITS, digits);
    write_register(CFG_CODE_LENGTH, len_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain: stop sending and wait for every expected result, so nothing is
  // in flight when the registers change.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Key in the stored code and confirm with '#'. A wrong attempt either
  // changes one digit or is one digit too long or too short.
  task automatic try_passcode(input bit correct);
    int n;
    int bad_pos;
    logic [DIGIT_W-1:0] nib;
    if ($urandom_range(0, 1)) send_keypress(KEY_STAR, stray_level(), stray_level());
    n = int'(cur_len);
    bad_pos = -1;
    if (!correct) begin
      if ($urandom_range(0, 1) && n > 0) bad_pos = $urandom_range(0, n - 1);
      else if (n == 0) n = 1;
      else n = $urandom_range(0, 1) ? n + 1 : n - 1;
    end
    for (int i = 0; i < n; i++) begin
      nib = (i < CODE_SLOTS) ? cur_code[DIGIT_W*i +: DIGIT_W] : 4'd0;
      // a stored nibble above nine cannot be keyed in at all
      if (nib > 4'd9) nib = 4'($urandom_range(0, 9));
      if (i == bad_pos) nib = 4'((nib + $urandom_range(1, 9)) % 10);
      send_keypress(KEY_DIGIT_LO + nib, stray_level(), stray_level());
    end
    send_keypress(KEY_HASH, stray_level(), stray_level());
  endtask

  // Switch activity, in order and out of order
  task automatic arm_stages();
    case ($urandom_range(0, 3))
      0: begin
        send_keypress(KEY_NONE, 1'b1, 1'b0);
        send_keypress(KEY_NONE, 1'b0, 1'b1);
      end
      1: send_keypress(KEY_NONE, 1'b1, 1'b1);
      2: send_keypress(KEY_NONE, 1'b0, 1'b1);
      default: begin
        send_keypress(KEY_DIGIT_LO + 4'($urandom_range(0, 9)), 1'b1, 1'b0);
        send_keypress(KEY_NONE, 1'b1, 1'b1);
        send_keypress(4'($urandom_range(0, 15)), 1'b1, 1'b1);
      end
    endcase
  endtask

  // Mostly well-formed code entries and arming, the rest noise, overflowing
  // digit runs and stray '*'.
  task automatic run_random(input int count);
    int target;
    target = sent_count + count;
    while (sent_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          try_passcode(1'b1);
          if ($urandom_range(0, 3) != 0) arm_stages();
        end
        4: try_passcode(1'b0);
        5, 6: send_keypress(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
        7: repeat ($urandom_range(9, 12))
             send_keypress(KEY_DIGIT_LO + 4'($urandom_range(0, 9)), 1'b0, 1'b0);
        8: send_keypress(KEY_STAR, stray_level(), stray_level());
        default: arm_stages();
      endcase
    end
  endtask

  initial begin
    logic [CODE_W-1:0] code;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.key           <= KEY_NONE;
    in_ch.safety_switch <= 1'b0;
    in_ch.fire_switch   <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_CODE_DIGITS;
    cfg_ch.data         <= '0;
    cur_code    = CODE_DIGITS_RST;
    cur_len     = CODE_LENGTH_RST;
    sent_count  = 0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, on the reset passcode 1,2,3,4
    send_keypress(KEY_NONE, 1'b0, 1'b0);
    send_keypress(KEY_NONE, 1'b1, 1'b0);      // safety while locked
    send_keypress(KEY_NONE, 1'b0, 1'b1);      // fire while locked
    send_keypress(4'd13, 1'b0, 1'b0);         // unused codes: no effect
    send_keypress(4'd15, 1'b0, 1'b0);
    send_keypress(KEY_DIGIT_LO + 4'd1, 1'b0, 1'b0);
    send_keypress(KEY_DIGIT_LO + 4'd2, 1'b0, 1'b0);
    send_keypress(KEY_DIGIT_LO + 4'd3, 1'b0, 1'b0);
    send_keypress(KEY_DIGIT_LO + 4'd4, 1'b0, 1'b0);
    send_keypress(KEY_HASH, 1'b0, 1'b0);      // match opens the lock
    send_keypress(KEY_NONE, 1'b1, 1'b0);      // safety stage
    send_keypress(KEY_NONE, 1'b0, 1'b1);      // fire stage
    send_keypress(KEY_STAR, 1'b0, 1'b0);      // star locks, stages kept
    send_keypress(KEY_HASH, 1'b0, 1'b0);      // empty entry: mismatch
    // ten digits fill the buffer (digits 0..9), the eleventh overflows
    for (int d = 0; d < MAX_DIGITS; d++) send_keypress(KEY_DIGIT_LO + 4'(d), 1'b0, 1'b0);
    send_keypress(KEY_DIGIT_LO, 1'b0, 1'b0);
    run_random(250);
    settle();

    // zero length code: '#' on an empty entry matches
    load_passcode(decimal_code(), 4'd0);
    send_keypress(KEY_STAR, 1'b0, 1'b0);
    send_keypress(KEY_HASH, 1'b0, 1'b0);
    run_random(100);
    settle();

    // longest code, all nines
    load_passcode({CODE_SLOTS{4'd9}}, 4'd10);
    try_passcode(1'b1);
    run_random(150);
    settle();

    // a stored nibble above nine can never be matched
    code = decimal_code();
    code[DIGIT_W +: DIGIT_W] = 4'($urandom_range(10, 15));
    load_passcode(code, 4'd3);
    try_passcode(1'b1);
    run_random(80);
    settle();

    // length beyond the buffer never matches
    load_passcode(decimal_code(), 4'd11);
    try_passcode(1'b1);
    run_random(60);
    settle();

    // single digit, all-zero code word
    load_passcode('0, 4'd1);
    run_random(100);
    settle();

    load_passcode(decimal_code(), 4'($urandom_range(1, 9)));
    run_random(110);
    settle();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
